// ===== rtl/core/eses_pkg.sv =====
// Shared types, constants and register indexes of the encoder edge speed estimator.
package eses_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned SPEED_W     = 24;
  localparam int unsigned ALPHA_W     = 17;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OUT_DEPTH   = 2;

  localparam logic [SPEED_W-1:0] SPEED_MAX   = 24'h7FFFFF;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h08000;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_REVERSED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA   = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] edge_time;
    logic              phase_b;
  } in_item_t;

  typedef struct packed {
    logic                      moving_forward;
    logic signed [SPEED_W-1:0] raw_speed;
    logic signed [SPEED_W-1:0] smoothed_speed;
  } out_item_t;

  // One classified edge handed from the front part to the back part.
  typedef struct packed {
    logic              forward;
    logic [TIME_W-1:0] interval;
  } edge_req_t;

  typedef struct packed {
    logic      valid;
    edge_req_t req;
  } edge_link_t;

endpackage

// ===== rtl/core/eses_front.sv =====
// Front part: accept edges, classify direction, measure interval, queue requests.
module eses_front
  import eses_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_data,
  input  logic       motor_reversed,
  input  logic       q_pop,
  output edge_link_t q_head
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  edge_req_t         q_mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic              do_push, do_pop;
  edge_req_t         new_req;

  assign in_full = (cnt_r == CNT_FULL);
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && (cnt_r != '0);

  assign new_req.forward  = (in_data.phase_b ^ motor_reversed) == 1'b0;
  assign new_req.interval = in_data.edge_time - prev_time_r;

  assign q_head.valid = (cnt_r != '0);
  assign q_head.req   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    cnt_nxt       = cnt_r;
    prev_time_nxt = prev_time_r;
    if (do_push) begin
      wr_ptr_nxt    = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      prev_time_nxt = in_data.edge_time;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      prev_time_r <= '0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      prev_time_r <= prev_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= new_req;
    end
  end

endmodule

// ===== rtl/core/eses_back.sv =====
// Back part: serial divide, saturate, sign, smooth and queue the result.
module eses_back
  import eses_pkg::*;
#(
  parameter int unsigned ODEPTH = OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  edge_link_t         q_head,
  output logic               q_pop,
  input  logic [TIME_W-1:0]  speed_scale,
  input  logic [ALPHA_W-1:0] filter_alpha,
  output logic               out_empty,
  input  logic               out_pop,
  output out_item_t          out_data
);

  localparam int unsigned PTR_W  = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(ODEPTH + 1);
  localparam int unsigned STEP_W = $clog2(TIME_W);
  localparam int unsigned PROD_W = ALPHA_W + SPEED_W + 2;
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(ODEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(ODEPTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TIME_W - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_WGT  = 5'b01000,
    ST_FIN  = 5'b10000
  } back_state_t;

  back_state_t               state_r, state_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [TIME_W-1:0]         rem_r, rem_nxt;
  logic [TIME_W-1:0]         quo_r, quo_nxt;
  logic [TIME_W-1:0]         div_r, div_nxt;
  logic                      fwd_r, fwd_nxt;
  logic signed [SPEED_W-1:0] raw_r, raw_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [SPEED_W-1:0] filt_r, filt_nxt;

  out_item_t         o_mem_r [ODEPTH];
  logic [PTR_W-1:0]  o_wr_r, o_wr_nxt;
  logic [PTR_W-1:0]  o_rd_r, o_rd_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic              o_push, o_pop;
  out_item_t         o_item;

  logic [TIME_W:0]           trial;
  logic [SPEED_W-1:0]        mag;
  logic [ALPHA_W-1:0]        alpha_c;
  logic signed [SPEED_W:0]   diff;
  logic signed [PROD_W-1:0]  sum;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_r, quo_r[TIME_W-1]} - {1'b0, div_r};

  // A zero divisor yields an all-ones quotient, which saturates like any overflow.
  assign mag     = (quo_r > TIME_W'(SPEED_MAX)) ? SPEED_MAX : quo_r[SPEED_W-1:0];
  assign alpha_c = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;
  assign diff    = {raw_r[SPEED_W-1], raw_r} - {filt_r[SPEED_W-1], filt_r};
  assign sum     = prod_r
                 + $signed({{(PROD_W-SPEED_W-16){filt_r[SPEED_W-1]}}, filt_r, 16'h0000})
                 + $signed(PROD_W'(32768));

  assign q_pop  = (state_r == ST_IDLE) && q_head.valid && (o_cnt_r != CNT_FULL);
  assign o_push = (state_r == ST_FIN);
  assign o_pop  = out_pop && (o_cnt_r != '0);

  assign o_item.moving_forward = fwd_r;
  assign o_item.raw_speed      = raw_r;
  assign o_item.smoothed_speed = sum[SPEED_W+15:16];

  assign out_empty = (o_cnt_r == '0);
  assign out_data  = o_mem_r[o_rd_r];

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    fwd_nxt   = fwd_r;
    raw_nxt   = raw_r;
    prod_nxt  = prod_r;
    filt_nxt  = filt_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          rem_nxt   = '0;
          quo_nxt   = speed_scale;
          div_nxt   = q_head.req.interval;
          fwd_nxt   = q_head.req.forward;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!trial[TIME_W]) begin
          rem_nxt = trial[TIME_W-1:0];
        end else begin
          rem_nxt = {rem_r[TIME_W-2:0], quo_r[TIME_W-1]};
        end
        quo_nxt  = {quo_r[TIME_W-2:0], ~trial[TIME_W]};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // Sign the magnitude; the weight step follows next cycle.
        raw_nxt   = fwd_r ? $signed(mag) : -$signed(mag);
        state_nxt = ST_WGT;
      end
      ST_WGT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        filt_nxt  = sum[SPEED_W+15:16];
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Product of the clamped weight and the step from the old average.
    if (state_r == ST_WGT) begin
      prod_nxt = $signed({1'b0, alpha_c}) * $signed({diff[SPEED_W], diff[SPEED_W:0]});
    end
  end

  always_comb begin
    o_wr_nxt  = o_wr_r;
    o_rd_nxt  = o_rd_r;
    o_cnt_nxt = o_cnt_r;
    if (o_push) begin
      o_wr_nxt = (o_wr_r == PTR_LAST) ? '0 : o_wr_r + 1'b1;
    end
    if (o_pop) begin
      o_rd_nxt = (o_rd_r == PTR_LAST) ? '0 : o_rd_r + 1'b1;
    end
    if (o_push && !o_pop) begin
      o_cnt_nxt = o_cnt_r + 1'b1;
    end else if (o_pop && !o_push) begin
      o_cnt_nxt = o_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      filt_r  <= '0;
      o_wr_r  <= '0;
      o_rd_r  <= '0;
      o_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      filt_r  <= filt_nxt;
      o_wr_r  <= o_wr_nxt;
      o_rd_r  <= o_rd_nxt;
      o_cnt_r <= o_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    fwd_r  <= fwd_nxt;
    raw_r  <= raw_nxt;
    prod_r <= prod_nxt;
    if (o_push) begin
      o_mem_r[o_wr_r] <= o_item;
    end
  end

endmodule

// ===== rtl/core/encoder_edge_speed_estimator_core.sv =====
// Top level of the encoder edge speed estimator: config registers, front and back parts.
// Each accepted request passes through dispatch, the divider steps, sign, weight multiply
//   and round before its result enters the output queue behind the out_ ports.
// The back part takes a new edge only once done with the last (bit-serial 32-bit divider).
// Reset (rst_n low, synchronous): queues empty, previous edge time and average cleared,
//   motor_reversed = 0, speed_scale = 0, filter_alpha = 0.5 (Q1.16).
module encoder_edge_speed_estimator_core
  import eses_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH,
  parameter int unsigned ODEPTH = OUT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic               motor_reversed_r, motor_reversed_nxt;
  logic [TIME_W-1:0]  speed_scale_r, speed_scale_nxt;
  logic [ALPHA_W-1:0] filter_alpha_r, filter_alpha_nxt;
  edge_link_t         q_head;
  logic               q_pop;

  // Register writes are registered; an index outside the map is dropped.
  always_comb begin
    motor_reversed_nxt = motor_reversed_r;
    speed_scale_nxt    = speed_scale_r;
    filter_alpha_nxt   = filter_alpha_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MOTOR_REVERSED: motor_reversed_nxt = cfg_data[0];
        CFG_SPEED_SCALE:    speed_scale_nxt    = cfg_data[TIME_W-1:0];
        CFG_FILTER_ALPHA:   filter_alpha_nxt   = cfg_data[ALPHA_W-1:0];
        default: begin
          motor_reversed_nxt = motor_reversed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_reversed_r <= 1'b0;
      speed_scale_r    <= '0;
      filter_alpha_r   <= ALPHA_RESET;
    end else begin
      motor_reversed_r <= motor_reversed_nxt;
      speed_scale_r    <= speed_scale_nxt;
      filter_alpha_r   <= filter_alpha_nxt;
    end
  end

  // Front: take each edge, fix its direction and interval, and hold the request
  // in a short queue so the input side never waits on the divider directly.
  eses_front #(
    .QDEPTH(QDEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data        (in_data),
    .motor_reversed (motor_reversed_r),
    .q_pop          (q_pop),
    .q_head         (q_head)
  );

  // Back: divide, saturate, sign and smooth one request at a time, then park
  // the result in the output queue until the consumer pops it.
  eses_back #(
    .ODEPTH(ODEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .speed_scale  (speed_scale_r),
    .filter_alpha (filter_alpha_r),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_data     (out_data)
  );

endmodule
